/* sv/wtg_pkg.sv */
// shared types, constants and register codes of the window trigger generator
package wtg_pkg;

  localparam int TS_W                = 63;   // timestamp width
  localparam int CFG_DATA_W          = 32;   // widest configuration register
  localparam int CFG_IDX_W           = 2;    // register index width
  localparam int MAX_WINDOWS_DEFAULT = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_MODE  = 2'd0,
    CFG_WINDOW_SIZE  = 2'd1,
    CFG_SLIDE_LENGTH = 2'd2
  } cfg_index_t;

  localparam logic MODE_TUMBLING = 1'b0;
  localparam logic MODE_SLIDING  = 1'b1;

  localparam logic                  WINDOW_MODE_RESET  = MODE_TUMBLING;
  localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RESET  = 32'd1000;
  localparam logic [CFG_DATA_W-1:0] SLIDE_LENGTH_RESET = 32'd1000;

  typedef struct packed {
    logic [TS_W-1:0] previous_watermark;
    logic [TS_W-1:0] current_watermark;
  } watermark_t;

  typedef struct packed {
    logic [TS_W-1:0] window_start;
    logic [TS_W-1:0] window_end;
    logic            last_window;
    logic            truncated;
  } window_t;

  // request and response of the remainder unit
  typedef struct packed {
    logic                  start;
    logic [TS_W-1:0]       dividend;
    logic [CFG_DATA_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                  done;
    logic [CFG_DATA_W-1:0] remainder;
  } rem_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN
  } state_t;

endpackage

/* sv/wtg_stream_if.sv */
// valid/ready stream interface carrying one payload struct per beat
interface wtg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/wtg_rem_unit.sv */
// restoring remainder unit: one dividend bit per cycle
module wtg_rem_unit (
  input  logic              clk,
  input  logic              rst,
  input  wtg_pkg::rem_req_t req,
  output wtg_pkg::rem_rsp_t rsp
);
  import wtg_pkg::*;

  localparam int CNT_W = $clog2(TS_W);

  logic [TS_W-1:0]       dvd;
  logic [CFG_DATA_W-1:0] dvs;
  logic [CFG_DATA_W-1:0] rem;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [CFG_DATA_W:0]   trial;
  logic [CFG_DATA_W+1:0] diff;

  always_comb begin
    trial = {rem, dvd[TS_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= CNT_W'(TS_W - 1);
    end else if (busy) begin
      dvd <= {dvd[TS_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (!diff[CFG_DATA_W+1]) begin
        rem <= diff[CFG_DATA_W-1:0];
      end else begin
        rem <= trial[CFG_DATA_W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

/* sv/window_trigger_generator_top.sv */
// top level of the window trigger generator: config, sequencer and window scan
//
//  channel     dir  payload                                          beat when
//  watermarks  in   previous_watermark, current_watermark            valid && ready
//  windows     out  window_start, window_end, last_window, truncated  valid && ready
//  cfg         in   cfg_index, cfg_data (window_mode/size/slide)     cfg_write
//
// an accepted watermark beat starts a run; a run with a zero size, a zero slide
// in sliding mode, or a current watermark below the size in sliding mode ends at once
// otherwise the remainder unit runs through its bit steps and signals done; then the
// scan checks one candidate window per cycle while the output register can take a result,
// the scan loop setting the per-window rate
// the scan waits whenever the output register is full and not taken; watermarks
// is ready only between runs, a pending result may still be held in the output
// synchronous active-high reset; no clearing pass, no memories
module window_trigger_generator_top #(
  parameter int MAX_WINDOWS = wtg_pkg::MAX_WINDOWS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtg_pkg::CFG_DATA_W-1:0] cfg_data,
  wtg_stream_if.sink                     watermarks,
  wtg_stream_if.source                   windows
);
  import wtg_pkg::*;

  localparam int              CNT_W   = $clog2(MAX_WINDOWS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOWS);
  // candidate start: signed, with room for end = start + size and start - slide
  localparam int              WS_W    = TS_W + 2;

  // configuration registers
  logic                  window_mode;
  logic [CFG_DATA_W-1:0] window_size;
  logic [CFG_DATA_W-1:0] slide_length;

  state_t state, state_next;

  // run registers
  logic [TS_W-1:0]        base;    // value whose remainder aligns the first start
  logic [TS_W-1:0]        limit;   // current watermark (tumbling) or previous (sliding)
  logic signed [WS_W-1:0] ws;      // candidate window start
  logic                   have_pend;
  logic [CNT_W-1:0]       pend_count;
  logic [TS_W-1:0]        pend_start;
  logic [TS_W-1:0]        pend_end;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  // datapath
  logic                   in_beat;
  logic                   skip_run;
  logic [TS_W-1:0]        dividend_sel;
  logic signed [WS_W-1:0] end_sum;
  logic signed [WS_W-1:0] ws_step;
  logic signed [WS_W-1:0] limit_s;
  logic                   due;
  logic                   out_free;

  // sequencer outputs
  logic step;       // candidate is due: move it into the pending slot
  logic load_out;   // pending window goes into the output register
  logic out_last;
  logic out_trunc;
  logic finish;

  assign in_beat  = watermarks.valid && watermarks.ready;
  assign out_free = !windows.valid || windows.ready;

  // runs with nothing to emit, and the divide operand of each mode
  always_comb begin
    skip_run = (window_size == '0) ||
               (window_mode == MODE_SLIDING &&
                (slide_length == '0 ||
                 watermarks.data.current_watermark < TS_W'(window_size)));
    if (window_mode == MODE_SLIDING) begin
      // sliding: latest start whose end fits is (cur - size) aligned to the slide
      dividend_sel = watermarks.data.current_watermark - TS_W'(window_size);
    end else begin
      // tumbling: previous watermark aligned to the size
      dividend_sel = watermarks.data.previous_watermark;
    end
  end

  // candidate evaluation: one wide add and compare, plus the slide subtract in sliding mode
  always_comb begin
    end_sum = ws + $signed(WS_W'(window_size));
    limit_s = $signed(WS_W'(limit));
    if (window_mode == MODE_SLIDING) begin
      ws_step = ws - $signed(WS_W'(slide_length));
      due     = !ws[WS_W-1] && (end_sum > limit_s);
    end else begin
      ws_step = end_sum;
      due     = end_sum <= limit_s;
    end
  end

  wtg_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (rem_req.start) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_rsp.done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    watermarks.ready = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = dividend_sel;
    rem_req.divisor  = (window_mode == MODE_SLIDING) ? slide_length : window_size;
    step             = 1'b0;
    load_out         = 1'b0;
    out_last         = 1'b0;
    out_trunc        = 1'b0;
    finish           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        watermarks.ready = 1'b1;
        rem_req.start    = in_beat && !skip_run;
      end
      ST_DIVIDE: begin
      end
      ST_SCAN: begin
        if (out_free) begin
          priority if (due && have_pend && pend_count == CNT_MAX) begin
            // cap reached with one more window due
            load_out  = 1'b1;
            out_last  = 1'b1;
            out_trunc = 1'b1;
            finish    = 1'b1;
          end else if (due) begin
            step     = 1'b1;
            load_out = have_pend;
          end else if (have_pend) begin
            load_out = 1'b1;
            out_last = 1'b1;
            finish   = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_mode   <= WINDOW_MODE_RESET;
      window_size   <= WINDOW_SIZE_RESET;
      slide_length  <= SLIDE_LENGTH_RESET;
      have_pend     <= 1'b0;
      pend_count    <= '0;
      windows.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WINDOW_MODE:  window_mode  <= cfg_data[0];
          CFG_WINDOW_SIZE:  window_size  <= cfg_data;
          CFG_SLIDE_LENGTH: slide_length <= cfg_data;
          default: begin
          end
        endcase
      end
      if (finish) begin
        have_pend  <= 1'b0;
        pend_count <= '0;
      end else if (step) begin
        have_pend  <= 1'b1;
        pend_count <= pend_count + 1'b1;
      end
      if (load_out) begin
        windows.valid <= 1'b1;
      end else if (windows.ready) begin
        windows.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      base  <= dividend_sel;
      limit <= (window_mode == MODE_SLIDING) ? watermarks.data.previous_watermark
                                              : watermarks.data.current_watermark;
    end
    if (rem_rsp.done) begin
      // first candidate: operand minus its remainder
      ws <= $signed(WS_W'(base) - WS_W'(rem_rsp.remainder));
    end else if (step) begin
      ws <= ws_step;
    end
    if (step) begin
      pend_start <= ws[TS_W-1:0];
      pend_end   <= end_sum[TS_W-1:0];
    end
    if (load_out) begin
      windows.data.window_start <= pend_start;
      windows.data.window_end   <= pend_end;
      windows.data.last_window  <= out_last;
      windows.data.truncated    <= out_trunc;
    end
  end

  // the remainder unit answers only while the sequencer waits for it
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    rem_rsp.done |-> state == ST_DIVIDE)
    else $error("remainder done outside divide state");

  // the pending count never passes the cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    pend_count <= CNT_MAX)
    else $error("pending window count above cap");

  // a held window implies a nonzero count
  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    have_pend |-> pend_count != '0)
    else $error("pending window with zero count");

  // truncation is only flagged on the final window of a run
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    windows.valid && windows.data.truncated |-> windows.data.last_window)
    else $error("truncated window not marked last");

endmodule

/* bench/wtg_window_checker.sv */
// window checker: tracks the config, predicts the windows of each watermark beat and compares
module wtg_window_checker #(
  parameter int MAX_WINDOWS = wtg_pkg::MAX_WINDOWS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           wm_valid,
  input  logic                           wm_ready,
  input  wtg_pkg::watermark_t            wm_data,
  input  logic                           win_valid,
  input  logic                           win_ready,
  input  wtg_pkg::window_t               win_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import wtg_pkg::*;

  logic                  mode_q;
  logic [CFG_DATA_W-1:0] size_q;
  logic [CFG_DATA_W-1:0] slide_q;
  window_t               due_windows[$];
  window_t               head_w;
  int                    errors = 0;

  // queue every window that one watermark step closes, flags on the final one
  function automatic void predict_windows(input logic [TS_W-1:0] prev,
                                          input logic [TS_W-1:0] cur);
    longint unsigned u_prev, u_cur, u_size, u_ws;
    longint          s_size, s_slide, s_prev, s_cur, rem, s_ws, lo, hi, over;
    longint          starts[$];
    int              n;
    window_t         w;
    u_prev  = 64'(prev);
    u_cur   = 64'(cur);
    u_size  = 64'(size_q);
    s_size  = 64'(size_q);
    s_slide = 64'(slide_q);
    s_prev  = 64'(prev);
    s_cur   = 64'(cur);
    if (size_q == '0) return;
    // collect up to one start past the cap so truncation can be seen
    if (mode_q == MODE_TUMBLING) begin
      u_ws = u_prev - (u_prev % u_size);
      while (u_ws + u_size <= u_cur && starts.size() <= MAX_WINDOWS) begin
        starts.push_back(u_ws);
        u_ws += u_size;
      end
    end else begin
      if (slide_q == '0) return;
      rem  = s_cur % s_slide;
      s_ws = s_cur - rem;
      lo   = s_prev - s_size;
      hi   = s_cur - s_size;
      over = s_size - rem;
      if (over > 0) s_ws -= ((over + s_slide - 1) / s_slide) * s_slide;
      while (s_ws > lo && s_ws >= 0 && s_ws <= hi && starts.size() <= MAX_WINDOWS) begin
        starts.push_back(s_ws);
        s_ws -= s_slide;
      end
    end
    n = (starts.size() > MAX_WINDOWS) ? MAX_WINDOWS : starts.size();
    for (int i = 0; i < n; i++) begin
      w.window_start = TS_W'(starts[i]);
      w.window_end   = TS_W'(starts[i] + s_size);
      w.last_window  = (i == n - 1);
      w.truncated    = (i == n - 1) && (starts.size() > MAX_WINDOWS);
      due_windows.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode_q  = WINDOW_MODE_RESET;
      size_q  = WINDOW_SIZE_RESET;
      slide_q = SLIDE_LENGTH_RESET;
      due_windows.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_WINDOW_MODE:  mode_q  = cfg_data[0];
          CFG_WINDOW_SIZE:  size_q  = cfg_data;
          CFG_SLIDE_LENGTH: slide_q = cfg_data;
          default: ;
        endcase
      end
      // results first: a beat taken now can't explain a window leaving now
      if (win_valid && win_ready) begin
        if (due_windows.size() == 0) begin
          $display("%0t unexpected window: expected none, actual start %0d end %0d last %0b trunc %0b",
                   $time, win_data.window_start, win_data.window_end,
                   win_data.last_window, win_data.truncated);
          errors++;
        end else begin
          head_w = due_windows.pop_front();
          if (win_data.window_start !== head_w.window_start ||
              win_data.window_end   !== head_w.window_end   ||
              win_data.last_window  !== head_w.last_window  ||
              win_data.truncated    !== head_w.truncated) begin
            $display("%0t window mismatch: expected start %0d end %0d last %0b trunc %0b",
                     $time, head_w.window_start, head_w.window_end,
                     head_w.last_window, head_w.truncated);
            $display("%0t                  actual   start %0d end %0d last %0b trunc %0b",
                     $time, win_data.window_start, win_data.window_end,
                     win_data.last_window, win_data.truncated);
            errors++;
          end
        end
      end
      if (wm_valid && wm_ready)
        predict_windows(wm_data.previous_watermark, wm_data.current_watermark);
    end
    fail_count <= errors;
    pending    <= due_windows.size();
  end

endmodule

/* bench/tb.sv */
// testbench top: clock, reset, config phases, watermark stimulus, receiver and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wtg_pkg::*;

  localparam int MAX_WIN        = MAX_WINDOWS_DEFAULT;
  localparam int DRAIN_CYCLES   = 200;   // a run with no windows still passes through the divide
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int RAND_PHASES    = 11;
  localparam int PHASE_ITEMS    = 35;

  localparam logic [TS_W-1:0]       TS_TOP  = '1;  // largest timestamp
  localparam logic [63:0]           TS_MAX  = {1'b0, {TS_W{1'b1}}};
  localparam logic [CFG_DATA_W-1:0] LEN_MAX = '1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // knobs shared by the driving processes, always changed with nonblocking writes
  logic idle_on;   // random bubbles on both sides
  logic hold_req;  // ask the receiver for one long hold-off

  logic i_hold_done = 1'b0;  // owned by the receiver process

  int fail_count;
  int pending;
  int quiet_cycles;

  logic                  mode_r;
  logic [CFG_DATA_W-1:0] size_r, slide_r, len_r;
  watermark_t            wm_r;

  wtg_stream_if #(.payload_t(watermark_t)) wm_if ();
  wtg_stream_if #(.payload_t(window_t))    win_if ();

  window_trigger_generator_top #(.MAX_WINDOWS(MAX_WIN)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .watermarks (wm_if),
    .windows    (win_if)
  );

  // checker watches both channels and the config port, owns all prediction
  wtg_window_checker #(.MAX_WINDOWS(MAX_WIN)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wm_valid   (wm_if.valid),
    .wm_ready   (wm_if.ready),
    .wm_data    (wm_if.data),
    .win_valid  (win_if.valid),
    .win_ready  (win_if.ready),
    .win_data   (win_if.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wait until the block is idle: no window still owed, the latency of a run
  // that emits nothing has passed, and the watermark side takes beats again
  task automatic settle();
    wm_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!wm_if.ready) @(posedge clk);
  endtask

  // write all three registers back to back, write enable held high throughout
  task automatic set_phase(input logic mode, input logic [CFG_DATA_W-1:0] size,
                           input logic [CFG_DATA_W-1:0] slide);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_WINDOW_MODE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cfg_index <= CFG_SLIDE_LENGTH;
    cfg_data  <= slide;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // offer one watermark beat, maybe after a short bubble, and wait for the take;
  // valid stays high so back-to-back beats need no second write in one step
  task automatic send_item(input logic [TS_W-1:0] prev, input logic [TS_W-1:0] cur);
    watermark_t w;
    w.previous_watermark = prev;
    w.current_watermark  = cur;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      wm_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    wm_if.valid <= 1'b1;
    wm_if.data  <= w;
    do @(posedge clk); while (!wm_if.ready);
  endtask

  // window size or slide: mostly moderate, with tiny, huge, full-range and zero
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    else if (sel < 3) return CFG_DATA_W'($urandom_range(1, 16));
    else if (sel == 3) return LEN_MAX;
    else if (sel < 6) return $urandom;
    else return CFG_DATA_W'($urandom_range(50, 5000));
  endfunction

  // mostly well-formed steps a few windows long from low, random or top-end
  // bases; some steps around the cap, backwards, fully random or empty
  function automatic watermark_t pick_watermarks(input logic [CFG_DATA_W-1:0] len);
    logic [63:0] r, base, span, hi_ts;
    watermark_t  w;
    int          kind;
    kind = $urandom_range(0, 9);
    r    = {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0:       base = 64'($urandom_range(0, 1000000));
      1:       base = {1'b0, r[TS_W-1:0]};
      default: base = TS_MAX - 64'($urandom_range(0, 100000));
    endcase
    if (kind == 6) span = 64'(len) * 64'($urandom_range(60, 70));
    else span = 64'(len) * 64'($urandom_range(0, 4)) + 64'($urandom_range(0, len)) +
                64'($urandom_range(0, 3));
    hi_ts = base + span;
    if (hi_ts > TS_MAX) hi_ts = TS_MAX;
    w.previous_watermark = base[TS_W-1:0];
    w.current_watermark  = hi_ts[TS_W-1:0];
    if (kind == 7) begin
      w.previous_watermark = hi_ts[TS_W-1:0];
      w.current_watermark  = base[TS_W-1:0];
    end else if (kind == 8) begin
      r = {$urandom, $urandom};
      w.previous_watermark = r[TS_W-1:0];
      r = {$urandom, $urandom};
      w.current_watermark  = r[TS_W-1:0];
    end else if (kind == 9) begin
      w.current_watermark  = w.previous_watermark;
    end
    return w;
  endfunction

  // receiver: bursts of ready high and short bubbles, plus one long hold-off
  // on request while the sender keeps offering, so the block backs up
  initial begin
    win_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && quiet_cycles >= 0 && HOLD_CYCLES > 0 && !i_hold_done) begin
        win_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        i_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        win_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        win_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // watchdog: any beat or config write counts as progress
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((wm_if.valid && wm_if.ready) || (win_if.valid && win_if.ready) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= CFG_WINDOW_MODE;
    cfg_data    <= '0;
    wm_if.valid <= 1'b0;
    wm_if.data  <= '0;
    idle_on     <= 1'b1;
    hold_req    <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: tumbling, size 1000
    send_item('0, '0);                         // nothing due
    send_item('0, 63'd999);                    // one short of the first window
    send_item('0, 63'd1000);                   // exactly one window
    send_item(63'd1500, 63'd4200);             // unaligned previous watermark
    send_item(63'd5000, 63'd1000);             // previous above current
    send_item('0, 63'd64000);                  // exactly at the cap, not truncated
    send_item('0, 63'd65000);                  // one past the cap, truncated
    send_item(TS_TOP - 63'd2500, TS_TOP);      // top of the timestamp range
    send_item(TS_TOP, TS_TOP);

    // tumbling extremes of the size
    set_phase(MODE_TUMBLING, 32'd1, 32'd1000);
    send_item(63'd7, 63'd100);
    set_phase(MODE_TUMBLING, LEN_MAX, 32'd1000);
    send_item('0, TS_TOP);
    send_item(63'd12345, 63'd12345 + 63'd2 * 63'(LEN_MAX));

    // zero size emits nothing
    set_phase(MODE_TUMBLING, '0, 32'd1000);
    send_item('0, TS_TOP);

    // sliding with overlapping windows
    set_phase(MODE_SLIDING, 32'd3000, 32'd1000);
    send_item('0, 63'd5500);
    send_item(63'd2000, 63'd10000);
    send_item('0, 63'd2999);                   // current below the size
    send_item(TS_TOP - 63'd10000, TS_TOP);

    // sliding with gaps between windows
    set_phase(MODE_SLIDING, 32'd1000, 32'd3000);
    send_item('0, 63'd20000);
    send_item(63'd4000, 63'd4500);

    // zero slide and zero size in sliding mode
    set_phase(MODE_SLIDING, 32'd1000, '0);
    send_item('0, 63'd10000);
    set_phase(MODE_SLIDING, '0, 32'd1000);
    send_item('0, 63'd10000);

    // sliding extremes: huge size with unit slide, huge slide with unit size
    set_phase(MODE_SLIDING, LEN_MAX, 32'd1);
    send_item('0, TS_TOP);
    set_phase(MODE_SLIDING, 32'd1, LEN_MAX);
    send_item(63'd5, TS_TOP);
    send_item(TS_TOP - 63'd5, TS_TOP);

    // unit size and slide: every step is a window, capped
    set_phase(MODE_SLIDING, 32'd1, 32'd1);
    send_item(63'd100, 63'd200);

    // random phases; one gets the long receiver hold-off, the last one runs
    // without bubbles on either side
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) idle_on <= 1'b0;
      mode_r  = 1'($urandom_range(0, 1));
      size_r  = pick_length();
      slide_r = pick_length();
      if (ph == 2) begin
        mode_r = MODE_TUMBLING;
        size_r = 32'd100;
      end
      set_phase(mode_r, size_r, slide_r);
      if (ph == 2) hold_req <= 1'b1;
      // step the watermark by the spacing that actually produces windows
      len_r = (mode_r == MODE_SLIDING && slide_r > size_r) ? slide_r : size_r;
      repeat (PHASE_ITEMS) begin
        wm_r = pick_watermarks(len_r);
        send_item(wm_r.previous_watermark, wm_r.current_watermark);
      end
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
sv/wtg_pkg.sv
sv/wtg_stream_if.sv
sv/wtg_rem_unit.sv
sv/window_trigger_generator_top.sv
bench/wtg_window_checker.sv
bench/tb.sv
